### rtl/euler_fly_camera_update_assert.svh
// ----------------------------------------------------------------------------
// fly camera assertion macros
// shared property forms for the camera update checks
// ----------------------------------------------------------------------------
`ifndef EULER_FLY_CAMERA_UPDATE_ASSERT_SVH
`define EULER_FLY_CAMERA_UPDATE_ASSERT_SVH

// same-cycle implication, quiet while in reset
`define EFC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while in reset
`define EFC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/efc_pkg.sv
// ----------------------------------------------------------------------------
// fly camera package
// shared codes, constants, command types and fixed point helpers
// ----------------------------------------------------------------------------
`default_nettype none

package efc_pkg;

  // request kinds
  localparam logic [1:0] REQ_PLACE  = 2'd0;
  localparam logic [1:0] REQ_KEY    = 2'd1;
  localparam logic [1:0] REQ_MOUSE  = 2'd2;
  localparam logic [1:0] REQ_SCROLL = 2'd3;

  // move directions
  localparam logic [1:0] DIR_FWD   = 2'd0;
  localparam logic [1:0] DIR_BACK  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  // register indexes
  localparam logic [2:0] CFG_SPEED  = 3'd0;
  localparam logic [2:0] CFG_GAIN   = 3'd1;
  localparam logic [2:0] CFG_UP_X   = 3'd2;
  localparam logic [2:0] CFG_UP_Y   = 3'd3;
  localparam logic [2:0] CFG_UP_Z   = 3'd4;
  localparam logic [2:0] CFG_YAW0   = 3'd5;
  localparam logic [2:0] CFG_PITCH0 = 3'd6;
  localparam logic [2:0] CFG_ZOOM0  = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  // datapath operations
  localparam logic [4:0] OP_NONE   = 5'd0;
  localparam logic [4:0] OP_LOAD   = 5'd1;
  localparam logic [4:0] OP_PLACE  = 5'd2;
  localparam logic [4:0] OP_MOUSE  = 5'd3;
  localparam logic [4:0] OP_WYI    = 5'd4;
  localparam logic [4:0] OP_WPI    = 5'd5;
  localparam logic [4:0] OP_WSTEP  = 5'd6;
  localparam logic [4:0] OP_WYD    = 5'd7;
  localparam logic [4:0] OP_WPD    = 5'd8;
  localparam logic [4:0] OP_CYI    = 5'd9;
  localparam logic [4:0] OP_CPI    = 5'd10;
  localparam logic [4:0] OP_CSTEP  = 5'd11;
  localparam logic [4:0] OP_CYD    = 5'd12;
  localparam logic [4:0] OP_CPD    = 5'd13;
  localparam logic [4:0] OP_FR0    = 5'd14;
  localparam logic [4:0] OP_FR1    = 5'd15;
  localparam logic [4:0] OP_CR0    = 5'd16;
  localparam logic [4:0] OP_CR1    = 5'd17;
  localparam logic [4:0] OP_SQ     = 5'd18;
  localparam logic [4:0] OP_N2     = 5'd19;
  localparam logic [4:0] OP_SQI    = 5'd20;
  localparam logic [4:0] OP_SQS    = 5'd21;
  localparam logic [4:0] OP_DVI    = 5'd22;
  localparam logic [4:0] OP_DVS    = 5'd23;
  localparam logic [4:0] OP_DVD    = 5'd24;
  localparam logic [4:0] OP_VEL    = 5'd25;
  localparam logic [4:0] OP_DISP   = 5'd26;
  localparam logic [4:0] OP_MOVE   = 5'd27;
  localparam logic [4:0] OP_SCROLL = 5'd28;
  localparam logic [4:0] OP_PUB    = 5'd29;

  // iteration counts
  localparam int WRAP_N   = 8;
  localparam int CORDIC_N = 16;
  localparam int SQRT_N   = 32;
  localparam int DIV_N    = 16;

  // angles, degrees in Q16.16
  localparam logic signed [25:0] DEG1    = 26'sd65536;
  localparam logic signed [25:0] DEG45   = 26'sd2949120;
  localparam logic signed [33:0] DEG89   = 34'sd5832704;
  localparam logic signed [25:0] DEG90   = 26'sd5898240;
  localparam logic signed [25:0] DEG180  = 26'sd11796480;
  localparam logic [33:0]        WRAP_MOD = 34'd23592960;
  // half turn plus 128 full turns keeps the reduction operand positive
  localparam logic signed [35:0] WRAP_OFS = 36'sd3031695360;

  localparam logic [21:0]        ZOOM_MIN = 22'd65536;
  localparam logic [21:0]        ZOOM_MAX = 22'd2949120;
  localparam logic signed [24:0] YAW_LO   = -25'sd11796480;
  localparam logic signed [24:0] YAW_HI   = 25'sd11796480;

  localparam logic signed [31:0] CORDIC_K = 32'sd652032874;
  localparam logic signed [15:0] VMAX     = 16'sd16384;

  // reset values
  localparam logic [23:0]        SPEED_RST = 24'd163840;
  localparam logic [15:0]        GAIN_RST  = 16'd6554;
  localparam logic signed [24:0] YAW_RST   = -25'sd5898240;

  typedef struct packed {
    logic [4:0] op;
    logic [4:0] idx;
  } cmd_t;

  typedef struct packed {
    logic cross_zero;
  } stat_t;

  function automatic logic signed [25:0] atan_deg(input logic [3:0] i);
    logic signed [25:0] a;
    case (i)
      4'd0:    a = 26'sd2949120;
      4'd1:    a = 26'sd1740967;
      4'd2:    a = 26'sd919879;
      4'd3:    a = 26'sd466945;
      4'd4:    a = 26'sd234379;
      4'd5:    a = 26'sd117304;
      4'd6:    a = 26'sd58666;
      4'd7:    a = 26'sd29335;
      4'd8:    a = 26'sd14668;
      4'd9:    a = 26'sd7334;
      4'd10:   a = 26'sd3667;
      4'd11:   a = 26'sd1833;
      4'd12:   a = 26'sd917;
      4'd13:   a = 26'sd458;
      4'd14:   a = 26'sd229;
      default: a = 26'sd115;
    endcase
    return a;
  endfunction

  // shift right, round half away from zero
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input logic [5:0] s);
    logic signed [63:0] h;
    h = 64'sd1 <<< (s - 6'd1);
    if (v >= 0) begin
      return (v + h) >>> s;
    end else begin
      return -((-v + h) >>> s);
    end
  endfunction

  function automatic logic signed [15:0] sat_vec(input logic signed [63:0] v);
    if (v > 64'sd16384) begin
      return VMAX;
    end else if (v < -64'sd16384) begin
      return -VMAX;
    end else begin
      return v[15:0];
    end
  endfunction

endpackage

`default_nettype wire

### rtl/efc_ctrl.sv
// ----------------------------------------------------------------------------
// fly camera controller
// sequences the datapath through one request and owns both handshakes
// ----------------------------------------------------------------------------
`default_nettype none

module efc_ctrl
  import efc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] req_type,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire stat_t      stat,
  output cmd_t            cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_PLACE  = 5'd1;
  localparam logic [4:0] S_MOUSE  = 5'd2;
  localparam logic [4:0] S_WYI    = 5'd3;
  localparam logic [4:0] S_WYS    = 5'd4;
  localparam logic [4:0] S_WYD    = 5'd5;
  localparam logic [4:0] S_WPI    = 5'd6;
  localparam logic [4:0] S_WPS    = 5'd7;
  localparam logic [4:0] S_WPD    = 5'd8;
  localparam logic [4:0] S_CYI    = 5'd9;
  localparam logic [4:0] S_CYS    = 5'd10;
  localparam logic [4:0] S_CYD    = 5'd11;
  localparam logic [4:0] S_CPI    = 5'd12;
  localparam logic [4:0] S_CPS    = 5'd13;
  localparam logic [4:0] S_CPD    = 5'd14;
  localparam logic [4:0] S_FR0    = 5'd15;
  localparam logic [4:0] S_FR1    = 5'd16;
  localparam logic [4:0] S_CR0    = 5'd17;
  localparam logic [4:0] S_CR1    = 5'd18;
  localparam logic [4:0] S_SQ     = 5'd19;
  localparam logic [4:0] S_N2     = 5'd20;
  localparam logic [4:0] S_SQI    = 5'd21;
  localparam logic [4:0] S_SQS    = 5'd22;
  localparam logic [4:0] S_DVI    = 5'd23;
  localparam logic [4:0] S_DVS    = 5'd24;
  localparam logic [4:0] S_DVD    = 5'd25;
  localparam logic [4:0] S_VEL    = 5'd26;
  localparam logic [4:0] S_DISP   = 5'd27;
  localparam logic [4:0] S_MOVE   = 5'd28;
  localparam logic [4:0] S_SCROLL = 5'd29;
  localparam logic [4:0] S_DONE   = 5'd30;

  localparam logic [4:0] WRAP_LAST   = 5'(WRAP_N - 1);
  localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_N - 1);
  localparam logic [4:0] SQRT_LAST   = 5'(SQRT_N - 1);
  localparam logic [4:0] DIV_LAST    = 5'(DIV_N - 1);

  logic [4:0] state, state_next;
  logic [4:0] cnt, cnt_next;
  logic       out_valid_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cmd.op         = OP_NONE;
    cmd.idx        = cnt;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
          unique case (req_type)
            REQ_PLACE: state_next = S_PLACE;
            REQ_KEY:   state_next = S_VEL;
            REQ_MOUSE: state_next = S_MOUSE;
            default:   state_next = S_SCROLL;
          endcase
        end
      end
      S_PLACE: begin cmd.op = OP_PLACE; state_next = S_WYI; end
      S_MOUSE: begin cmd.op = OP_MOUSE; state_next = S_WYI; end
      S_WYI: begin cmd.op = OP_WYI; cnt_next = '0; state_next = S_WYS; end
      S_WYS: begin
        cmd.op = OP_WSTEP;
        cnt_next = cnt + 5'd1;
        if (cnt == WRAP_LAST) begin
          state_next = S_WYD;
        end
      end
      S_WYD: begin cmd.op = OP_WYD; state_next = S_WPI; end
      S_WPI: begin cmd.op = OP_WPI; cnt_next = '0; state_next = S_WPS; end
      S_WPS: begin
        cmd.op = OP_WSTEP;
        cnt_next = cnt + 5'd1;
        if (cnt == WRAP_LAST) begin
          state_next = S_WPD;
        end
      end
      S_WPD: begin cmd.op = OP_WPD; state_next = S_CYI; end
      S_CYI: begin cmd.op = OP_CYI; cnt_next = '0; state_next = S_CYS; end
      S_CYS: begin
        cmd.op = OP_CSTEP;
        cnt_next = cnt + 5'd1;
        if (cnt == CORDIC_LAST) begin
          state_next = S_CYD;
        end
      end
      S_CYD: begin cmd.op = OP_CYD; state_next = S_CPI; end
      S_CPI: begin cmd.op = OP_CPI; cnt_next = '0; state_next = S_CPS; end
      S_CPS: begin
        cmd.op = OP_CSTEP;
        cnt_next = cnt + 5'd1;
        if (cnt == CORDIC_LAST) begin
          state_next = S_CPD;
        end
      end
      S_CPD: begin cmd.op = OP_CPD; state_next = S_FR0; end
      S_FR0: begin cmd.op = OP_FR0; state_next = S_FR1; end
      S_FR1: begin cmd.op = OP_FR1; state_next = S_CR0; end
      S_CR0: begin cmd.op = OP_CR0; state_next = S_CR1; end
      S_CR1: begin cmd.op = OP_CR1; state_next = S_SQ; end
      S_SQ:  begin cmd.op = OP_SQ;  state_next = S_N2; end
      S_N2:  begin cmd.op = OP_N2;  state_next = S_SQI; end
      S_SQI: begin
        // a zero cross product leaves right as it was
        cnt_next = '0;
        if (stat.cross_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.op = OP_SQI;
          state_next = S_SQS;
        end
      end
      S_SQS: begin
        cmd.op = OP_SQS;
        cnt_next = cnt + 5'd1;
        if (cnt == SQRT_LAST) begin
          state_next = S_DVI;
        end
      end
      S_DVI: begin cmd.op = OP_DVI; cnt_next = '0; state_next = S_DVS; end
      S_DVS: begin
        cmd.op = OP_DVS;
        cnt_next = cnt + 5'd1;
        if (cnt == DIV_LAST) begin
          state_next = S_DVD;
        end
      end
      S_DVD:    begin cmd.op = OP_DVD;    state_next = S_DONE; end
      S_VEL:    begin cmd.op = OP_VEL;    state_next = S_DISP; end
      S_DISP:   begin cmd.op = OP_DISP;   state_next = S_MOVE; end
      S_MOVE:   begin cmd.op = OP_MOVE;   state_next = S_DONE; end
      S_SCROLL: begin cmd.op = OP_SCROLL; state_next = S_DONE; end
      S_DONE: begin
        // wait until the output register is free
        if (!out_valid || !out_stall) begin
          cmd.op = OP_PUB;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

### rtl/efc_datapath.sv
// ----------------------------------------------------------------------------
// fly camera datapath
// registers, camera state, angle wrap, cordic, square root and dividers
// ----------------------------------------------------------------------------
`default_nettype none

module efc_datapath
  import efc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire cmd_t                    cmd,
  output stat_t                        stat,
  input  wire logic                    cfg_write,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [1:0]              req_type,
  input  wire logic [1:0]              move_dir,
  input  wire logic [15:0]             frame_dt,
  input  wire logic signed [15:0]      mouse_dx,
  input  wire logic signed [15:0]      mouse_dy,
  input  wire logic                    clamp_pitch,
  input  wire logic signed [7:0]       scroll_steps,
  input  wire logic signed [31:0]      place_x,
  input  wire logic signed [31:0]      place_y,
  input  wire logic signed [31:0]      place_z,
  output logic signed [31:0]           cam_x,
  output logic signed [31:0]           cam_y,
  output logic signed [31:0]           cam_z,
  output logic signed [15:0]           front_x,
  output logic signed [15:0]           front_y,
  output logic signed [15:0]           front_z,
  output logic signed [15:0]           right_x,
  output logic signed [15:0]           right_y,
  output logic signed [15:0]           right_z,
  output logic [21:0]                  zoom_angle,
  output logic signed [24:0]           yaw_angle,
  output logic signed [24:0]           pitch_angle
);

  // configuration
  logic [23:0]        speed;
  logic [15:0]        gain;
  logic signed [15:0] up [3];
  logic signed [24:0] yaw0;
  logic signed [23:0] pitch0;
  logic [21:0]        zoom0;

  // camera state
  logic signed [31:0] pos [3];
  logic signed [24:0] yaw, pitch;
  logic [21:0]        zoom;
  logic signed [15:0] look [3];
  logic signed [15:0] side [3];

  // latched request
  logic [1:0]         req_r, dir_r;
  logic [15:0]        dt_r;
  logic signed [15:0] dx_r, dy_r;
  logic               clamp_r;
  logic signed [7:0]  steps_r;
  logic signed [31:0] place_r [3];

  // working registers
  logic signed [33:0] asum_y, asum_p;
  logic [33:0]        wr;
  logic signed [25:0] cor_a;
  logic signed [31:0] cor_x, cor_y;
  logic               flip;
  logic signed [31:0] cy, sy, cp, sp;
  logic signed [63:0] p0, p2;
  logic signed [31:0] m [6];
  logic signed [31:0] c [3];
  logic [63:0]        sq [3];
  logic [63:0]        n2;
  logic [63:0]        sq_n, sq_r;
  logic [31:0]        dv_rem [3];
  logic [15:0]        dv_lo [3];
  logic [15:0]        dv_q [3];
  logic               dv_neg [3];
  logic [23:0]        vel;
  logic signed [40:0] dp [3];

  // combinational helpers
  logic signed [32:0] mdx, mdy;
  logic [33:0]        wlim;
  logic signed [24:0] wrap_out;
  logic signed [24:0] pitch_out;
  logic signed [25:0] fold_src, fold_a;
  logic               fold_flip;
  logic signed [31:0] cdx, cdy;
  logic signed [25:0] catan;
  logic [63:0]        sq_bit, sq_t;
  logic [31:0]        mag;
  logic signed [31:0] move_out [3];
  logic signed [63:0] move_d [3];
  logic signed [63:0] move_p [3];
  logic signed [15:0] vsel [3];
  logic               move_neg;
  logic signed [25:0] zs;
  logic [21:0]        scroll_out, zoom_place;
  logic [47:0]        dv_num [3];
  logic [31:0]        dv_abs [3];
  logic [32:0]        dv_t [3];

  function automatic logic signed [25:0] scroll_steps_ext(input logic signed [7:0] s);
    return 26'(s);
  endfunction

  assign stat.cross_zero = (n2 == '0);
  assign mag = sq_r[31:0];

  always_comb begin
    mdx = dx_r * $signed({1'b0, gain});
    mdy = dy_r * $signed({1'b0, gain});

    wlim = WRAP_MOD << (3'd7 - cmd.idx[2:0]);
    wrap_out = 25'($signed({1'b0, wr[24:0]}) - DEG180);
    if (req_r == REQ_MOUSE && clamp_r) begin
      if (asum_p > DEG89) begin
        pitch_out = 25'(DEG89);
      end else if (asum_p < -DEG89) begin
        pitch_out = 25'(-DEG89);
      end else begin
        pitch_out = asum_p[24:0];
      end
    end else begin
      pitch_out = wrap_out;
    end

    // fold the angle into the cordic range
    fold_src = (cmd.op == OP_CYI) ? 26'(yaw) : 26'(pitch);
    if (fold_src > DEG90) begin
      fold_a = fold_src - DEG180;
      fold_flip = 1'b1;
    end else if (fold_src < -DEG90) begin
      fold_a = fold_src + DEG180;
      fold_flip = 1'b1;
    end else begin
      fold_a = fold_src;
      fold_flip = 1'b0;
    end
    cdx = cor_y >>> cmd.idx[3:0];
    cdy = cor_x >>> cmd.idx[3:0];
    catan = atan_deg(cmd.idx[3:0]);

    sq_bit = 64'd1 << (6'd62 - {cmd.idx, 1'b0});
    sq_t = sq_r + sq_bit;

    move_neg = (dir_r == DIR_BACK) || (dir_r == DIR_LEFT);
    for (int k = 0; k < 3; k++) begin
      vsel[k] = (dir_r == DIR_FWD || dir_r == DIR_BACK) ? look[k] : side[k];
      move_d[k] = rnd_shr(64'(dp[k]), 6'd14);
      move_p[k] = move_neg ? (64'(pos[k]) - move_d[k]) : (64'(pos[k]) + move_d[k]);
      if (move_p[k] > 64'sd2147483647) begin
        move_out[k] = 32'sh7fffffff;
      end else if (move_p[k] < -64'sd2147483648) begin
        move_out[k] = 32'sh80000000;
      end else begin
        move_out[k] = move_p[k][31:0];
      end
      dv_abs[k] = c[k][31] ? 32'(-c[k]) : 32'(c[k]);
      dv_num[k] = (48'(dv_abs[k]) << 14) + 48'(mag[31:1]);
      dv_t[k] = {dv_rem[k], dv_lo[k][15]};
    end

    zs = $signed({4'b0, zoom}) - (26'(scroll_steps_ext(steps_r)) <<< 16);
    if (zs < DEG1) begin
      scroll_out = ZOOM_MIN;
    end else if (zs > DEG45) begin
      scroll_out = ZOOM_MAX;
    end else begin
      scroll_out = zs[21:0];
    end
    if (zoom0 < ZOOM_MIN) begin
      zoom_place = ZOOM_MIN;
    end else if (zoom0 > ZOOM_MAX) begin
      zoom_place = ZOOM_MAX;
    end else begin
      zoom_place = zoom0;
    end
  end

  // configuration and camera state
  always_ff @(posedge clk) begin
    if (rst) begin
      speed  <= SPEED_RST;
      gain   <= GAIN_RST;
      up[0]  <= '0;
      up[1]  <= VMAX;
      up[2]  <= '0;
      yaw0   <= YAW_RST;
      pitch0 <= '0;
      zoom0  <= ZOOM_MAX;
      for (int k = 0; k < 3; k++) begin
        pos[k] <= '0;
      end
      yaw     <= YAW_RST;
      pitch   <= '0;
      zoom    <= ZOOM_MAX;
      look[0] <= '0;
      look[1] <= '0;
      look[2] <= -VMAX;
      side[0] <= VMAX;
      side[1] <= '0;
      side[2] <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_SPEED:  speed  <= cfg_data[23:0];
          CFG_GAIN:   gain   <= cfg_data[15:0];
          CFG_UP_X:   up[0]  <= cfg_data[15:0];
          CFG_UP_Y:   up[1]  <= cfg_data[15:0];
          CFG_UP_Z:   up[2]  <= cfg_data[15:0];
          CFG_YAW0:   yaw0   <= cfg_data[24:0];
          CFG_PITCH0: pitch0 <= cfg_data[23:0];
          CFG_ZOOM0:  zoom0  <= cfg_data[21:0];
          default: ;
        endcase
      end
      unique case (cmd.op)
        OP_PLACE: begin
          for (int k = 0; k < 3; k++) begin
            pos[k] <= place_r[k];
          end
          zoom <= zoom_place;
        end
        OP_WYD: yaw <= wrap_out;
        OP_WPD: pitch <= pitch_out;
        OP_FR1: begin
          look[0] <= sat_vec(rnd_shr(p0, 6'd46));
          look[1] <= sat_vec(rnd_shr(64'(sp), 6'd16));
          look[2] <= sat_vec(rnd_shr(p2, 6'd46));
        end
        OP_DVD: begin
          for (int k = 0; k < 3; k++) begin
            side[k] <= sat_vec(dv_neg[k] ? -$signed(64'(dv_q[k])) : $signed(64'(dv_q[k])));
          end
        end
        OP_MOVE: begin
          for (int k = 0; k < 3; k++) begin
            pos[k] <= move_out[k];
          end
        end
        OP_SCROLL: zoom <= scroll_out;
        default: ;
      endcase
    end
  end

  // working registers and result register
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        req_r      <= req_type;
        dir_r      <= move_dir;
        dt_r       <= frame_dt;
        dx_r       <= mouse_dx;
        dy_r       <= mouse_dy;
        clamp_r    <= clamp_pitch;
        steps_r    <= scroll_steps;
        place_r[0] <= place_x;
        place_r[1] <= place_y;
        place_r[2] <= place_z;
      end
      OP_PLACE: begin
        asum_y <= 34'(yaw0);
        asum_p <= 34'(pitch0);
      end
      OP_MOUSE: begin
        asum_y <= 34'(yaw) + 34'(mdx);
        asum_p <= 34'(pitch) + 34'(mdy);
      end
      OP_WYI: wr <= 34'(36'(asum_y) + WRAP_OFS);
      OP_WPI: wr <= 34'(36'(asum_p) + WRAP_OFS);
      OP_WSTEP: begin
        if (wr >= wlim) begin
          wr <= wr - wlim;
        end
      end
      OP_CYI, OP_CPI: begin
        cor_a <= fold_a;
        flip  <= fold_flip;
        cor_x <= CORDIC_K;
        cor_y <= '0;
      end
      OP_CSTEP: begin
        if (cor_a >= 0) begin
          cor_x <= cor_x - cdx;
          cor_y <= cor_y + cdy;
          cor_a <= cor_a - catan;
        end else begin
          cor_x <= cor_x + cdx;
          cor_y <= cor_y - cdy;
          cor_a <= cor_a + catan;
        end
      end
      OP_CYD: begin
        cy <= flip ? -cor_x : cor_x;
        sy <= flip ? -cor_y : cor_y;
      end
      OP_CPD: begin
        cp <= flip ? -cor_x : cor_x;
        sp <= flip ? -cor_y : cor_y;
      end
      OP_FR0: begin
        p0 <= cy * cp;
        p2 <= sy * cp;
      end
      OP_CR0: begin
        m[0] <= look[1] * up[2];
        m[1] <= look[2] * up[1];
        m[2] <= look[2] * up[0];
        m[3] <= look[0] * up[2];
        m[4] <= look[0] * up[1];
        m[5] <= look[1] * up[0];
      end
      OP_CR1: begin
        c[0] <= m[0] - m[1];
        c[1] <= m[2] - m[3];
        c[2] <= m[4] - m[5];
      end
      OP_SQ: begin
        for (int k = 0; k < 3; k++) begin
          sq[k] <= 64'(c[k] * c[k]);
        end
      end
      OP_N2: n2 <= sq[0] + sq[1] + sq[2];
      OP_SQI: begin
        sq_n <= n2;
        sq_r <= '0;
      end
      OP_SQS: begin
        if (sq_n >= sq_t) begin
          sq_n <= sq_n - sq_t;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
      end
      OP_DVI: begin
        for (int k = 0; k < 3; k++) begin
          dv_rem[k] <= dv_num[k][47:16];
          dv_lo[k]  <= dv_num[k][15:0];
          dv_q[k]   <= '0;
          dv_neg[k] <= c[k][31];
        end
      end
      OP_DVS: begin
        for (int k = 0; k < 3; k++) begin
          dv_lo[k] <= dv_lo[k] << 1;
          if (dv_t[k] >= {1'b0, mag}) begin
            dv_rem[k] <= 32'(dv_t[k] - {1'b0, mag});
            dv_q[k]   <= {dv_q[k][14:0], 1'b1};
          end else begin
            dv_rem[k] <= dv_t[k][31:0];
            dv_q[k]   <= {dv_q[k][14:0], 1'b0};
          end
        end
      end
      OP_VEL: vel <= 24'((40'(speed) * 40'(dt_r) + 40'd32768) >> 16);
      OP_DISP: begin
        for (int k = 0; k < 3; k++) begin
          dp[k] <= $signed({1'b0, vel}) * vsel[k];
        end
      end
      OP_PUB: begin
        cam_x       <= pos[0];
        cam_y       <= pos[1];
        cam_z       <= pos[2];
        front_x     <= look[0];
        front_y     <= look[1];
        front_z     <= look[2];
        right_x     <= side[0];
        right_y     <= side[1];
        right_z     <= side[2];
        zoom_angle  <= zoom;
        yaw_angle   <= yaw;
        pitch_angle <= pitch;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/euler_fly_camera_update.sv
// ----------------------------------------------------------------------------
// fly camera update
// euler angle fly camera: place, key move, mouse look and scroll zoom
// ----------------------------------------------------------------------------
// One request is worked on at a time. A place or mouse request runs the angle
// wrap (two 8-step passes), the shared cordic unit (two 16-step passes for yaw
// and pitch), the bit-serial square root (32 steps) and the three 16-step
// dividers that normalize right. When the cross product is zero the square
// root and divide are skipped. A key request works out the velocity, the
// displacement and the move; a scroll request updates the zoom. The result
// sits in an output register, so the next request is accepted while the last
// result still waits. Registers may only be written while the block is idle.
`default_nettype none

`include "euler_fly_camera_update_assert.svh"

module euler_fly_camera_update
  import efc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            req_type,
  input  wire logic [1:0]            move_dir,
  input  wire logic [15:0]           frame_dt,
  input  wire logic signed [15:0]    mouse_dx,
  input  wire logic signed [15:0]    mouse_dy,
  input  wire logic                  clamp_pitch,
  input  wire logic signed [7:0]     scroll_steps,
  input  wire logic signed [31:0]    place_x,
  input  wire logic signed [31:0]    place_y,
  input  wire logic signed [31:0]    place_z,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [31:0]         cam_x,
  output logic signed [31:0]         cam_y,
  output logic signed [31:0]         cam_z,
  output logic signed [15:0]         front_x,
  output logic signed [15:0]         front_y,
  output logic signed [15:0]         front_z,
  output logic signed [15:0]         right_x,
  output logic signed [15:0]         right_y,
  output logic signed [15:0]         right_z,
  output logic [21:0]                zoom_angle,
  output logic signed [24:0]         yaw_angle,
  output logic signed [24:0]         pitch_angle
);

  cmd_t  cmd;
  stat_t stat;

  efc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  efc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_type     (req_type),
    .move_dir     (move_dir),
    .frame_dt     (frame_dt),
    .mouse_dx     (mouse_dx),
    .mouse_dy     (mouse_dy),
    .clamp_pitch  (clamp_pitch),
    .scroll_steps (scroll_steps),
    .place_x      (place_x),
    .place_y      (place_y),
    .place_z      (place_z),
    .cam_x        (cam_x),
    .cam_y        (cam_y),
    .cam_z        (cam_z),
    .front_x      (front_x),
    .front_y      (front_y),
    .front_z      (front_z),
    .right_x      (right_x),
    .right_y      (right_y),
    .right_z      (right_z),
    .zoom_angle   (zoom_angle),
    .yaw_angle    (yaw_angle),
    .pitch_angle  (pitch_angle)
  );

  `EFC_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "request not held off")
  `EFC_ASSERT_IMP(a_zoom_range, out_valid, zoom_angle >= ZOOM_MIN && zoom_angle <= ZOOM_MAX, "zoom out of range")
  `EFC_ASSERT_IMP(a_yaw_wrapped, out_valid, yaw_angle >= YAW_LO && yaw_angle < YAW_HI, "yaw not wrapped")
  `EFC_ASSERT_IMP(a_vec_range, out_valid, front_x >= -VMAX && front_x <= VMAX && right_x >= -VMAX && right_x <= VMAX, "vector out of range")

endmodule

`default_nettype wire
